// ===== hw/rtl/hrq_pkg.sv =====
// ----------------------------------------------------------------------------
// hrq_pkg
// shared types and constants of the hid report queue engine
// ----------------------------------------------------------------------------
package hrq_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_BUTTON   = 3'd0;
    localparam logic [2:0] OP_MODIFIER = 3'd1;
    localparam logic [2:0] OP_KEY      = 3'd2;
    localparam logic [2:0] OP_MOTION   = 3'd3;
    localparam logic [2:0] OP_SCROLL   = 3'd4;
    localparam logic [2:0] OP_SERVICE  = 3'd5;

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] CFG_MIDDLE_CODE = 2'd0;
    localparam logic [1:0] CFG_KEY_MIN     = 2'd1;
    localparam logic [1:0] CFG_KEY_MAX     = 2'd2;

    localparam logic [7:0] MIDDLE_CODE_RST = 8'd3;
    localparam logic [7:0] KEY_MIN_RST     = 8'd4;
    localparam logic [7:0] KEY_MAX_RST     = 8'd231;

    // number of modifier bits held
    localparam int unsigned MOD_COUNT = 4;

    typedef struct packed {
        logic [2:0]        operation;
        logic [7:0]        code;
        logic              pressed;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic signed [7:0] wheel_step;
        logic signed [7:0] pan_step;
        logic              link_ready;
        logic              mouse_free;
        logic              keyboard_free;
    } t_in_item;

    typedef struct packed {
        logic              mouse_send;
        logic [1:0]        mouse_buttons;
        logic signed [7:0] mouse_dx;
        logic signed [7:0] mouse_dy;
        logic signed [7:0] mouse_wheel;
        logic signed [7:0] mouse_pan;
        logic              key_send;
        logic [3:0]        key_modifiers;
        logic [47:0]       key_codes;
        logic [1:0]        current_buttons;
        logic [3:0]        current_modifiers;
        logic [47:0]       current_keys;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        buttons;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] wheel;
        logic signed [7:0] pan;
    } t_mouse_rep;

    typedef struct packed {
        logic [7:0] middle_code;
        logic [7:0] key_min;
        logic [7:0] key_max;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

endpackage

// ===== hw/rtl/hrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrq_ctrl
// sequencer: takes an item, runs the execute state, owns the result flag
// ----------------------------------------------------------------------------
module hrq_ctrl
    import hrq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_stall,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_ctrl_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic commit;

    // finish the item once the result register is free or being emptied
    assign commit = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.commit  = commit;

`ifndef NO_ASSERTIONS
    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_EXEC))
        else $error("captured item did not enter execute");
    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("finished item not presented");
`endif

endmodule

// ===== hw/rtl/hrq_datapath.sv =====
// ----------------------------------------------------------------------------
// hrq_datapath
// held state, two report queues in memory, delivery and result register
// ----------------------------------------------------------------------------
module hrq_datapath
    import hrq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH    = 128,
    parameter int unsigned KEY_SLOT_COUNT = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in_item,
    output t_out_item o_out_item
);

    localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW  = FW + 1;
    localparam int unsigned KW  = MOD_COUNT + 8 * KEY_SLOT_COUNT;
    localparam int unsigned SLW = (KEY_SLOT_COUNT > 1) ? $clog2(KEY_SLOT_COUNT) : 1;

    t_in_item   r_item;
    t_out_item  r_out;
    t_out_item  n_out;

    logic           r_linked,  n_linked;
    logic           r_mpend,   n_mpend;
    logic           r_kpend,   n_kpend;
    logic [1:0]     r_buttons, n_buttons;
    logic [3:0]     r_mods,    n_mods;
    logic [7:0]     r_slots [KEY_SLOT_COUNT];
    logic [7:0]     n_slots [KEY_SLOT_COUNT];
    logic [QW-1:0]  r_mhead,   n_mhead;
    logic [FW-1:0]  r_mfill,   n_mfill;
    logic [QW-1:0]  r_khead,   n_khead;
    logic [FW-1:0]  r_kfill,   n_kfill;

    // report memories, read data registered
    t_mouse_rep     mouse_mem [QUEUE_DEPTH];
    logic [KW-1:0]  kbd_mem   [QUEUE_DEPTH];
    t_mouse_rep     r_mrd;
    logic [KW-1:0]  r_krd;

    logic           m_we;
    logic           k_we;
    logic [QW-1:0]  m_waddr;
    logic [QW-1:0]  k_waddr;
    t_mouse_rep     m_wdata;
    logic [KW-1:0]  k_wdata;

    logic           m_push;
    logic           k_push;
    logic           in_range;
    logic           key_hit;
    logic           any_empty;
    logic [SLW-1:0] empty_idx;
    logic [1:0]     btn_mask;
    logic [3:0]     mod_mask;
    logic [SW-1:0]  m_sum;
    logic [SW-1:0]  k_sum;
    logic [47:0]    cur_keys;
    logic [47:0]    head_keys;

    // slot lookups, one key compare and one empty compare per slot
    always_comb begin
        key_hit   = 1'b0;
        any_empty = 1'b0;
        empty_idx = '0;
        for (int i = KEY_SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_slots[i] == r_item.code) begin
                key_hit = 1'b1;
            end
            if (r_slots[i] == 8'd0) begin
                any_empty = 1'b1;
                empty_idx = SLW'(i);
            end
        end
    end

    assign in_range = (r_item.code >= i_cfg.key_min) && (r_item.code <= i_cfg.key_max);
    assign btn_mask = (r_item.code == 8'd1) ? 2'b01 : 2'b10;
    assign mod_mask = 4'b0001 << r_item.code[1:0];

    // tail positions with wrap
    always_comb begin
        m_sum = SW'(r_mhead) + SW'(r_mfill);
        if (m_sum >= SW'(QUEUE_DEPTH)) begin
            m_sum = m_sum - SW'(QUEUE_DEPTH);
        end
        k_sum = SW'(r_khead) + SW'(r_kfill);
        if (k_sum >= SW'(QUEUE_DEPTH)) begin
            k_sum = k_sum - SW'(QUEUE_DEPTH);
        end
    end

    // queue head keyboard entry spread to one byte slot per key slot
    always_comb begin
        head_keys = '0;
        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
            head_keys[8*i +: 8] = r_krd[MOD_COUNT + 8*i +: 8];
        end
    end

    always_comb begin
        n_linked  = r_linked;
        n_mpend   = r_mpend;
        n_kpend   = r_kpend;
        n_buttons = r_buttons;
        n_mods    = r_mods;
        n_slots   = r_slots;
        n_mhead   = r_mhead;
        n_mfill   = r_mfill;
        n_khead   = r_khead;
        n_kfill   = r_kfill;
        m_push    = 1'b0;
        k_push    = 1'b0;
        m_wdata   = '0;
        n_out     = '0;

        unique case (r_item.operation)
            OP_BUTTON: begin
                if (r_item.code != i_cfg.middle_code) begin
                    n_buttons = r_item.pressed ? (r_buttons | btn_mask)
                                               : (r_buttons & ~btn_mask);
                    m_push = 1'b1;
                end
            end
            OP_MODIFIER: begin
                if (r_item.code < 8'd4) begin
                    n_mods = r_item.pressed ? (r_mods | mod_mask) : (r_mods & ~mod_mask);
                    k_push = 1'b1;
                end
            end
            OP_KEY: begin
                if (in_range) begin
                    if (r_item.pressed) begin
                        // a key already held changes nothing
                        if (!key_hit) begin
                            if (any_empty) begin
                                n_slots[empty_idx] = r_item.code;
                            end
                            k_push = 1'b1;
                        end
                    end else begin
                        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                            if (r_slots[i] == r_item.code) begin
                                n_slots[i] = 8'd0;
                            end
                        end
                        k_push = 1'b1;
                    end
                end
            end
            OP_MOTION: begin
                m_push     = 1'b1;
                m_wdata.dx = r_item.move_x;
                m_wdata.dy = r_item.move_y;
            end
            OP_SCROLL: begin
                m_push        = 1'b1;
                m_wdata.wheel = r_item.wheel_step;
                m_wdata.pan   = r_item.pan_step;
            end
            OP_SERVICE: begin
                if (!r_item.link_ready) begin
                    n_linked = 1'b0;
                    n_mhead  = '0;
                    n_mfill  = '0;
                    n_khead  = '0;
                    n_kfill  = '0;
                    n_mpend  = 1'b1;
                    n_kpend  = 1'b1;
                end else begin
                    n_linked = 1'b1;
                    // link coming up: snapshot both devices
                    if (!r_linked) begin
                        m_push = 1'b1;
                        k_push = 1'b1;
                    end
                    if (r_mpend) begin
                        if (r_item.mouse_free) begin
                            n_out.mouse_send = 1'b1;
                            n_mpend          = 1'b0;
                        end
                    end else if ((r_mfill != '0) && r_item.mouse_free) begin
                        n_out.mouse_send    = 1'b1;
                        n_out.mouse_buttons = r_mrd.buttons;
                        n_out.mouse_dx      = r_mrd.dx;
                        n_out.mouse_dy      = r_mrd.dy;
                        n_out.mouse_wheel   = r_mrd.wheel;
                        n_out.mouse_pan     = r_mrd.pan;
                        n_mhead = (r_mhead == QW'(QUEUE_DEPTH - 1)) ? '0 : r_mhead + 1'b1;
                        n_mfill = r_mfill - 1'b1;
                    end
                    if (r_kpend) begin
                        if (r_item.keyboard_free) begin
                            n_out.key_send = 1'b1;
                            n_kpend        = 1'b0;
                        end
                    end else if ((r_kfill != '0) && r_item.keyboard_free) begin
                        n_out.key_send      = 1'b1;
                        n_out.key_modifiers = r_krd[MOD_COUNT-1:0];
                        n_out.key_codes     = head_keys;
                        n_khead = (r_khead == QW'(QUEUE_DEPTH - 1)) ? '0 : r_khead + 1'b1;
                        n_kfill = r_kfill - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // enqueue only while linked; a full queue restarts behind a neutral report
        m_we    = m_push && n_linked;
        m_waddr = m_sum[QW-1:0];
        m_wdata.buttons = n_buttons;
        if (m_we) begin
            if (r_mfill >= FW'(QUEUE_DEPTH)) begin
                n_mhead = '0;
                n_mfill = FW'(1);
                n_mpend = 1'b1;
                m_waddr = '0;
                m_wdata = '0;
                m_wdata.buttons = n_buttons;
            end else begin
                n_mfill = r_mfill + 1'b1;
            end
        end

        k_we    = k_push && n_linked;
        k_waddr = k_sum[QW-1:0];
        if (k_we) begin
            if (r_kfill >= FW'(QUEUE_DEPTH)) begin
                n_khead = '0;
                n_kfill = FW'(1);
                n_kpend = 1'b1;
                k_waddr = '0;
            end else begin
                n_kfill = r_kfill + 1'b1;
            end
        end

        cur_keys = '0;
        k_wdata  = '0;
        k_wdata[MOD_COUNT-1:0] = n_mods;
        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
            cur_keys[8*i +: 8]            = n_slots[i];
            k_wdata[MOD_COUNT + 8*i +: 8] = n_slots[i];
        end

        n_out.current_buttons   = n_buttons;
        n_out.current_modifiers = n_mods;
        n_out.current_keys      = cur_keys;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && m_we) begin
            mouse_mem[m_waddr] <= m_wdata;
        end
        if (i_cmd.commit && k_we) begin
            kbd_mem[k_waddr] <= k_wdata;
        end
        r_mrd <= mouse_mem[r_mhead];
        r_krd <= kbd_mem[r_khead];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linked  <= 1'b0;
            r_mpend   <= 1'b1;
            r_kpend   <= 1'b1;
            r_buttons <= '0;
            r_mods    <= '0;
            r_mhead   <= '0;
            r_mfill   <= '0;
            r_khead   <= '0;
            r_kfill   <= '0;
            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_linked  <= n_linked;
            r_mpend   <= n_mpend;
            r_kpend   <= n_kpend;
            r_buttons <= n_buttons;
            r_mods    <= n_mods;
            r_mhead   <= n_mhead;
            r_mfill   <= n_mfill;
            r_khead   <= n_khead;
            r_kfill   <= n_kfill;
            r_slots   <= n_slots;
        end
    end

    assign o_out_item = r_out;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mfill <= FW'(QUEUE_DEPTH)) && (r_kfill <= FW'(QUEUE_DEPTH)))
        else $error("queue fill beyond depth");
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FW'(r_mhead) < FW'(QUEUE_DEPTH)) && (FW'(r_khead) < FW'(QUEUE_DEPTH)))
        else $error("queue head beyond depth");
    a_unlinked_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_linked |-> (r_mfill == '0) && (r_kfill == '0) && r_mpend && r_kpend)
        else $error("queues not empty while link down");
`endif

endmodule

// ===== hw/rtl/hid_report_queue_engine.sv =====
// ----------------------------------------------------------------------------
// hid_report_queue_engine
// mouse and keyboard event tracker with two report queues toward the host
// ----------------------------------------------------------------------------
// usage
//  - input channel (i_in_valid / o_in_stall / i_in_item): one beat per event
//    or service tick; accepted when valid is high and stall is low
//  - output channel (o_out_valid / i_out_stall / o_out_item): exactly one
//    beat per input beat, in order, carrying any delivered mouse and keyboard
//    report plus the held state after the event
//  - an accepted beat is captured, then executed and written back into the
//    result register; the next input beat is taken only after that
//    write-back, which the registered read of the queue head memories needs
//  - while a result waits under stall the next input beat is still taken;
//    its execution then holds until the result register is emptied
//  - apb configuration: middle_code at 0x0, key_usage_min 0x4, key_usage_max 0x8;
//    the user writes them only while the block is idle; no check enforces it
//  - reset (synchronous, active low) clears the held state, empties both
//    queues, drops the link and arms both neutral reports; queue memories
//    need no clearing pass as only written entries are ever read
// ----------------------------------------------------------------------------
module hid_report_queue_engine
    import hrq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH    = 128,
    parameter int unsigned KEY_SLOT_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // event channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,

    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [7:0] r_middle_code;
    logic [7:0] r_key_min;
    logic [7:0] r_key_max;
    logic       cfg_wr;
    t_cfg       cfg;
    t_ctrl_cmd  cmd;

    // write completes in the access phase; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_middle_code <= MIDDLE_CODE_RST;
            r_key_min     <= KEY_MIN_RST;
            r_key_max     <= KEY_MAX_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                CFG_MIDDLE_CODE: r_middle_code <= pwdata[7:0];
                CFG_KEY_MIN:     r_key_min     <= pwdata[7:0];
                CFG_KEY_MAX:     r_key_max     <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // readback, unused address reads as zero
    always_comb begin
        unique case (paddr[3:2])
            CFG_MIDDLE_CODE: prdata = {24'd0, r_middle_code};
            CFG_KEY_MIN:     prdata = {24'd0, r_key_min};
            CFG_KEY_MAX:     prdata = {24'd0, r_key_max};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.middle_code = r_middle_code;
    assign cfg.key_min     = r_key_min;
    assign cfg.key_max     = r_key_max;

    // sequencing: capture, then execute and write-back
    hrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // held state, report queues and result register
    hrq_datapath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .KEY_SLOT_COUNT (KEY_SLOT_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule
